>>> sv/assert_macros.svh
// Assertion helper macros shared by the knight path search RTL.
// Every macro samples on clock and is disabled while reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold on every clock edge.
`define ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Antecedent in one cycle implies the consequent in the next.
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> sv/knsp_pkg.sv
// Shared types and constants for the knight shortest path search block.
// No dependencies.
package knsp_pkg;

   localparam int MOVE_COUNT = 8;
   localparam int MAX_EMIT   = 7;

   // Knight move offsets in search order: (file, rank)
   localparam logic signed [2:0] STEP_FILE [MOVE_COUNT] =
      '{3'sd1, 3'sd2, -3'sd1, 3'sd2, 3'sd1, -3'sd2, -3'sd1, -3'sd2};
   localparam logic signed [2:0] STEP_RANK [MOVE_COUNT] =
      '{3'sd2, 3'sd1, 3'sd2, -3'sd1, -3'sd2, 3'sd1, -3'sd2, -3'sd1};

   // Controller to datapath
   typedef struct packed {
      logic load_query;  // latch start and target
      logic init;        // clear visited map, queue the start square
      logic pop_issue;   // advance queue head (read of head entry in flight)
      logic pop_take;    // load current square from queue read data
      logic exp_step;    // try one knight move from the current square
      logic walk_push;   // push current square on the path ring
      logic walk_take;   // current square <= its parent
      logic emit_load;   // load the output register with the next path square
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic off_board;     // start or target outside the board
      logic queue_empty;
      logic pop_is_target; // dequeued square equals target
      logic move_last;     // last of the eight moves
      logic walk_end;      // push reaches the start square or the length cap
      logic emit_last;     // final path square to emit
      logic out_free;      // output register can take a new transaction
   } status_type;

endpackage

>>> sv/knsp_if.sv
// Valid/ready channel interfaces for the knight path search block.
// Query channel carries start and target; result channel carries path squares.
interface knsp_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] start_file;
   logic [2:0] start_rank;
   logic [2:0] target_file;
   logic [2:0] target_rank;

   modport source (output valid, output start_file, output start_rank,
                   output target_file, output target_rank, input ready);
   modport sink   (input valid, input start_file, input start_rank,
                   input target_file, input target_rank, output ready);
endinterface

interface knsp_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] square_file;
   logic [2:0] square_rank;
   logic       last_of_path;

   modport source (output valid, output square_file, output square_rank,
                   output last_of_path, input ready);
   modport sink   (input valid, input square_file, input square_rank,
                   input last_of_path, output ready);
endinterface

>>> sv/knsp_ctrl.sv
// Sequencing state machine for the knight path search.
// Depends on knsp_pkg for the command and status structs.
module knsp_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  knsp_pkg::status_type status,
   output knsp_pkg::cmd_type    cmd
);
   import knsp_pkg::*;

   typedef enum logic [7:0] {
      ST_IDLE   = 8'b0000_0001,
      ST_INIT   = 8'b0000_0010,
      ST_POP    = 8'b0000_0100,
      ST_POPW   = 8'b0000_1000,
      ST_EXPAND = 8'b0001_0000,
      ST_WALK   = 8'b0010_0000,
      ST_WALKW  = 8'b0100_0000,
      ST_EMIT   = 8'b1000_0000
   } state_type;

   state_type state_ff;
   state_type state_in;

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_query = 1'b1;
               state_in       = ST_INIT;
            end
         end
         ST_INIT: begin
            if (status.off_board) begin
               state_in = ST_IDLE;
            end else begin
               cmd.init = 1'b1;
               state_in = ST_POP;
            end
         end
         ST_POP: begin
            if (status.queue_empty) begin
               state_in = ST_IDLE;
            end else begin
               cmd.pop_issue = 1'b1;
               state_in      = ST_POPW;
            end
         end
         ST_POPW: begin
            cmd.pop_take = 1'b1;
            state_in     = status.pop_is_target ? ST_WALK : ST_EXPAND;
         end
         ST_EXPAND: begin
            cmd.exp_step = 1'b1;
            if (status.move_last) state_in = ST_POP;
         end
         ST_WALK: begin
            cmd.walk_push = 1'b1;
            state_in      = status.walk_end ? ST_EMIT : ST_WALKW;
         end
         ST_WALKW: begin
            // parent read data for the current square is ready now
            cmd.walk_take = 1'b1;
            state_in      = ST_WALK;
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.emit_load = 1'b1;
               if (status.emit_last) state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

endmodule

>>> sv/knsp_datapath.sv
// Search datapath: visited bits, parent and queue memories, path ring, output register.
// Depends on knsp_pkg and assert_macros.svh.
`include "assert_macros.svh"

module knsp_datapath #(
   parameter int BOARD_SIZE = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  knsp_pkg::cmd_type    cmd,
   output knsp_pkg::status_type status,
   input  logic [2:0]           start_file,
   input  logic [2:0]           start_rank,
   input  logic [2:0]           target_file,
   input  logic [2:0]           target_rank,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [2:0]           rsp_square_file,
   output logic [2:0]           rsp_square_rank,
   output logic                 rsp_last_of_path
);
   import knsp_pkg::*;

   localparam int FW          = $clog2(BOARD_SIZE);
   localparam int AW          = 2 * FW;
   localparam int NUM_SQUARES = BOARD_SIZE * BOARD_SIZE;
   localparam int QA          = $clog2(NUM_SQUARES);
   localparam int CW          = QA + 1;
   localparam int SW          = FW + 2;

   // query
   logic [2:0]    sf_ff, sr_ff, tf_ff, tr_ff;
   logic [2:0]    sf_in, sr_in, tf_in, tr_in;
   logic [AW-1:0] start_sq, target_sq;

   // search
   logic [FW-1:0] cur_f_ff, cur_r_ff, cur_f_in, cur_r_in;
   logic [CW-1:0] head_ff, tail_ff, head_in, tail_in;
   logic [2:0]    move_ff, move_in;
   logic [2**AW-1:0] visited_ff, visited_in;
   logic [AW-1:0] queue_mem_ff [2**QA];
   logic [AW-1:0] parent_mem_ff [2**AW];
   logic [AW-1:0] q_rdata_ff, p_rdata_ff;

   logic signed [SW-1:0] nf, nr;
   logic          on_board, can_add;
   logic [AW-1:0] nx_sq, cur_sq;

   // path walk and emit
   logic [CW-1:0] depth_ff, depth_in;
   logic [2:0]    k_ff, k_in;
   logic [AW-1:0] ring_ff [8];
   logic [2:0]    ring_rd_idx;
   logic [AW-1:0] emit_sq;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [2:0]    rsp_f_ff, rsp_r_ff, rsp_f_in, rsp_r_in;
   logic          rsp_last_ff, rsp_last_in;

   assign start_sq  = {FW'(sf_ff), FW'(sr_ff)};
   assign target_sq = {FW'(tf_ff), FW'(tr_ff)};
   assign cur_sq    = {cur_f_ff, cur_r_ff};

   // one knight move from the current square
   assign nf       = signed'({2'b00, cur_f_ff}) + SW'(STEP_FILE[move_ff]);
   assign nr       = signed'({2'b00, cur_r_ff}) + SW'(STEP_RANK[move_ff]);
   assign on_board = !nf[SW-1] && !nr[SW-1] &&
                     (nf < SW'(BOARD_SIZE)) && (nr < SW'(BOARD_SIZE));
   assign nx_sq    = {nf[FW-1:0], nr[FW-1:0]};
   assign can_add  = on_board && !visited_ff[nx_sq] && (tail_ff < CW'(NUM_SQUARES));

   // ring holds the last eight pushes; start-side squares are the newest
   assign ring_rd_idx = depth_ff[2:0] - 3'd1 - k_ff;
   assign emit_sq     = ring_ff[ring_rd_idx];

   assign status.off_board     = (32'(sf_ff) >= BOARD_SIZE) || (32'(sr_ff) >= BOARD_SIZE) ||
                                 (32'(tf_ff) >= BOARD_SIZE) || (32'(tr_ff) >= BOARD_SIZE);
   assign status.queue_empty   = (head_ff == tail_ff);
   assign status.pop_is_target = (q_rdata_ff == target_sq);
   assign status.move_last     = (move_ff == 3'(MOVE_COUNT - 1));
   assign status.walk_end      = (cur_sq == start_sq) || (depth_ff == CW'(NUM_SQUARES - 1));
   assign status.emit_last     = (depth_ff == CW'(k_ff) + CW'(1)) ||
                                 (k_ff == 3'(MAX_EMIT - 1));
   assign status.out_free      = !rsp_valid_ff || rsp_ready;

   always_comb begin
      sf_in        = sf_ff;
      sr_in        = sr_ff;
      tf_in        = tf_ff;
      tr_in        = tr_ff;
      cur_f_in     = cur_f_ff;
      cur_r_in     = cur_r_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      move_in      = move_ff;
      visited_in   = visited_ff;
      depth_in     = depth_ff;
      k_in         = k_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_f_in     = rsp_f_ff;
      rsp_r_in     = rsp_r_ff;
      rsp_last_in  = rsp_last_ff;

      if (cmd.load_query) begin
         sf_in = start_file;
         sr_in = start_rank;
         tf_in = target_file;
         tr_in = target_rank;
      end
      if (cmd.init) begin
         visited_in           = '0;
         visited_in[start_sq] = 1'b1;
         head_in              = '0;
         tail_in              = CW'(1);
      end
      if (cmd.pop_issue) head_in = head_ff + CW'(1);
      if (cmd.pop_take) begin
         {cur_f_in, cur_r_in} = q_rdata_ff;
         move_in              = '0;
         depth_in             = '0;
      end
      if (cmd.exp_step) begin
         move_in = move_ff + 3'd1;
         if (can_add) begin
            visited_in[nx_sq] = 1'b1;
            tail_in           = tail_ff + CW'(1);
         end
      end
      if (cmd.walk_push) begin
         depth_in = depth_ff + CW'(1);
         k_in     = '0;
      end
      if (cmd.walk_take) {cur_f_in, cur_r_in} = p_rdata_ff;
      if (cmd.emit_load) begin
         rsp_valid_in = 1'b1;
         rsp_f_in     = 3'(emit_sq[AW-1:FW]);
         rsp_r_in     = 3'(emit_sq[FW-1:0]);
         rsp_last_in  = (depth_ff == CW'(k_ff) + CW'(1));
         k_in         = k_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         tail_ff      <= '0;
         visited_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         visited_ff   <= visited_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      sf_ff       <= sf_in;
      sr_ff       <= sr_in;
      tf_ff       <= tf_in;
      tr_ff       <= tr_in;
      cur_f_ff    <= cur_f_in;
      cur_r_ff    <= cur_r_in;
      move_ff     <= move_in;
      depth_ff    <= depth_in;
      k_ff        <= k_in;
      rsp_f_ff    <= rsp_f_in;
      rsp_r_ff    <= rsp_r_in;
      rsp_last_ff <= rsp_last_in;
   end

   // search queue: one write, one registered read at the head
   always_ff @(posedge clock) begin
      if (cmd.init) queue_mem_ff[QA'(0)] <= start_sq;
      else if (cmd.exp_step && can_add) queue_mem_ff[tail_ff[QA-1:0]] <= nx_sq;
      q_rdata_ff <= queue_mem_ff[head_ff[QA-1:0]];
   end

   // parent table: one write, one registered read at the current square
   always_ff @(posedge clock) begin
      if (cmd.init) parent_mem_ff[start_sq] <= start_sq;
      else if (cmd.exp_step && can_add) parent_mem_ff[nx_sq] <= cur_sq;
      p_rdata_ff <= parent_mem_ff[cur_sq];
   end

   always_ff @(posedge clock) begin
      if (cmd.walk_push) ring_ff[depth_ff[2:0]] <= cur_sq;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_square_file  = rsp_f_ff;
   assign rsp_square_rank  = rsp_r_ff;
   assign rsp_last_of_path = rsp_last_ff;

   `ASSERT_ALWAYS(a_head_le_tail, head_ff <= tail_ff, "queue head passed tail")
   `ASSERT_ALWAYS(a_tail_bound, tail_ff <= CW'(NUM_SQUARES), "queue tail beyond board")
   `ASSERT_NEXT(a_init_ptrs, cmd.init, (head_ff == '0) && (tail_ff == CW'(1)),
                "queue pointers wrong after init")
   `ASSERT_NEXT(a_emit_valid, cmd.emit_load, rsp_valid_ff, "emitted square not presented")

endmodule

>>> sv/knight_shortest_path_bfs_core.sv
// Knight shortest path by breadth-first search, one query at a time.
// Steps: latch and init, then per dequeued square a queue read plus eight move trials,
// then the target dequeue, a walk back from the target to the start square, and the
// emission of the path squares. The next query is taken the cycle after the last
// path square is loaded into the output register.
// Reset (synchronous, active high) clears controller, queue pointers, visited bits, valid.
module knight_shortest_path_bfs_core #(
   parameter int BOARD_SIZE = 8
) (
   input logic          clock,
   input logic          reset,
   knsp_req_if.sink     req_chan,
   knsp_rsp_if.source   rsp_chan
);
   import knsp_pkg::*;

   cmd_type    cmd;
   status_type status;
   logic       req_ready;

   knsp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   knsp_datapath #(
      .BOARD_SIZE (BOARD_SIZE)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .start_file       (req_chan.start_file),
      .start_rank       (req_chan.start_rank),
      .target_file      (req_chan.target_file),
      .target_rank      (req_chan.target_rank),
      .rsp_valid        (rsp_chan.valid),
      .rsp_ready        (rsp_chan.ready),
      .rsp_square_file  (rsp_chan.square_file),
      .rsp_square_rank  (rsp_chan.square_rank),
      .rsp_last_of_path (rsp_chan.last_of_path)
   );

   assign req_chan.ready = req_ready;

endmodule
